FILE: rtl/necd_pkg.sv
// necd_pkg: shared types, codes and reset constants of the NEC IR frame decoder.
// No dependencies; the interfaces, the frame check and the top level use it.

package necd_pkg;

  // Field widths
  localparam int unsigned TickW    = 14;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned FrameW   = 4 * ByteW;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = TickW;

  // Leader plus 32 data periods
  localparam logic [IdxW-1:0] FramePeriods = IdxW'(33);

  // Register reset values
  localparam logic [TickW-1:0] MinZeroRst  = TickW'(600);
  localparam logic [TickW-1:0] MinOneRst   = TickW'(1000);
  localparam logic [TickW-1:0] MaxOneRst   = TickW'(2000);
  localparam logic [TickW-1:0] TimeoutRst  = TickW'(10000);
  localparam logic [ByteW-1:0] CodeRst     = '0;

  // Register indexes on the configuration channel
  typedef enum logic [CfgIdxW-1:0] {
    CfgMinZero  = 4'd0,
    CfgMinOne   = 4'd1,
    CfgMaxOne   = 4'd2,
    CfgTimeout  = 4'd3,
    CfgExpAddr  = 4'd4,
    CfgVolUp    = 4'd5,
    CfgVolDown  = 4'd6,
    CfgMute     = 4'd7
  } cfg_idx_e;

  typedef enum logic [2:0] {
    StatusOk       = 3'd0,
    StatusTimeout  = 3'd1,
    StatusBadTime  = 3'd2,
    StatusAddrFail = 3'd3,
    StatusCmdFail  = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    ActNone    = 2'd0,
    ActVolUp   = 2'd1,
    ActVolDown = 2'd2,
    ActMute    = 2'd3
  } action_e;

  // Dispatch codes seen by the frame check
  typedef struct packed {
    logic [ByteW-1:0] exp_addr;
    logic [ByteW-1:0] vol_up;
    logic [ByteW-1:0] vol_down;
    logic [ByteW-1:0] mute;
  } dispatch_cfg_t;

  // One result item
  typedef struct packed {
    status_e          status;
    logic [ByteW-1:0] address;
    logic [ByteW-1:0] command;
    action_e          action;
  } result_t;

endpackage

FILE: rtl/necd_if.sv
// necd_if: valid/ready channels of the NEC IR frame decoder (input, result, config).
// Depends on necd_pkg for field widths and codes.

interface necd_in_if;
  logic                           valid;
  logic                           ready;
  logic [necd_pkg::TickW-1:0]     period_count;

  modport source (output valid, output period_count, input ready);
  modport sink   (input valid, input period_count, output ready);
endinterface

interface necd_out_if;
  logic                           valid;
  logic                           ready;
  necd_pkg::status_e              status;
  logic [necd_pkg::ByteW-1:0]     address;
  logic [necd_pkg::ByteW-1:0]     command;
  necd_pkg::action_e              action;

  modport source (output valid, output status, output address, output command,
                  output action, input ready);
  modport sink   (input valid, input status, input address, input command,
                  input action, output ready);
endinterface

interface necd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [necd_pkg::CfgIdxW-1:0]   reg_index;
  logic [necd_pkg::CfgDataW-1:0]  wdata;

  modport source (output valid, output reg_index, output wdata, input ready);
  modport sink   (input valid, input reg_index, input wdata, output ready);
endinterface

FILE: rtl/necd_frame_check.sv
// necd_frame_check: checks the 32 collected bits of a frame and picks the action.
// Depends on necd_pkg; purely combinational, used by the top level.

module necd_frame_check (
  input  logic [necd_pkg::FrameW-1:0] frame_i,
  input  logic                        timing_bad_i,
  input  necd_pkg::dispatch_cfg_t     cfg_i,
  output necd_pkg::result_t           result_o
);

  logic [necd_pkg::ByteW-1:0] b0, b1, b2, b3;
  logic                       addr_ok, cmd_ok;
  necd_pkg::action_e          act;

  // Bytes arrive in order address, ~address, command, ~command
  assign b0 = frame_i[4*necd_pkg::ByteW-1 -: necd_pkg::ByteW];
  assign b1 = frame_i[3*necd_pkg::ByteW-1 -: necd_pkg::ByteW];
  assign b2 = frame_i[2*necd_pkg::ByteW-1 -: necd_pkg::ByteW];
  assign b3 = frame_i[necd_pkg::ByteW-1 -: necd_pkg::ByteW];

  assign addr_ok = (b0 == ~b1);
  assign cmd_ok  = (b2 == ~b3);

  // Dispatch: an all-zero frame and a foreign address do nothing
  always_comb begin
    act = necd_pkg::ActNone;
    if ((b0 != '0 || b2 != '0) && b0 == cfg_i.exp_addr) begin
      if (b2 == cfg_i.vol_up) begin
        act = necd_pkg::ActVolUp;
      end else if (b2 == cfg_i.vol_down) begin
        act = necd_pkg::ActVolDown;
      end else if (b2 == cfg_i.mute) begin
        act = necd_pkg::ActMute;
      end
    end
  end

  // Status priority: timing, address check, command check
  always_comb begin
    result_o = '{status: necd_pkg::StatusOk, address: '0, command: '0,
                 action: necd_pkg::ActNone};
    if (timing_bad_i) begin
      result_o.status = necd_pkg::StatusBadTime;
    end else if (!addr_ok) begin
      result_o.status = necd_pkg::StatusAddrFail;
    end else if (!cmd_ok) begin
      result_o.status = necd_pkg::StatusCmdFail;
    end else begin
      result_o.address = b0;
      result_o.command = b2;
      result_o.action  = act;
    end
  end

endmodule

FILE: rtl/nec_ir_frame_decoder.sv
// nec_ir_frame_decoder: NEC IR frame decoder, one pulse period per input item.
// Depends on necd_pkg, the channels in necd_if and necd_frame_check.
//
//   channel  dir  payload                              item
//   in_i     in   period_count[13:0]                   one pulse period in ticks
//   out_o    out  status, address, command, action     one frame result
//   cfg_i    in   reg_index[3:0], wdata[13:0]          one register write
//
// One item per cycle while the result is not stalled; an input item sits in the input
// register after the edge that accepts it and then updates the frame state and, at a frame
// end or timeout, the result register (frame update and check in one pass).
// Reset clears the frame state, the valid flags and loads the register defaults.
// A stalled result holds the update stage; input stays ready while the input
// register is empty or its item moves on in the same cycle.

module nec_ir_frame_decoder (
  input  logic           clk_i,
  input  logic           rst_ni,
  necd_in_if.sink        in_i,
  necd_out_if.source     out_o,
  necd_cfg_if.sink       cfg_i
);

  // Configuration registers
  logic [necd_pkg::TickW-1:0] min_zero_q, min_one_q, max_one_q, timeout_q;
  necd_pkg::dispatch_cfg_t    disp_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_zero_q <= necd_pkg::MinZeroRst;
      min_one_q  <= necd_pkg::MinOneRst;
      max_one_q  <= necd_pkg::MaxOneRst;
      timeout_q  <= necd_pkg::TimeoutRst;
      disp_q     <= '{exp_addr: necd_pkg::CodeRst, vol_up: necd_pkg::CodeRst,
                      vol_down: necd_pkg::CodeRst, mute: necd_pkg::CodeRst};
    end else if (cfg_i.valid) begin
      unique case (necd_pkg::cfg_idx_e'(cfg_i.reg_index))
        necd_pkg::CfgMinZero: min_zero_q      <= cfg_i.wdata;
        necd_pkg::CfgMinOne:  min_one_q       <= cfg_i.wdata;
        necd_pkg::CfgMaxOne:  max_one_q       <= cfg_i.wdata;
        necd_pkg::CfgTimeout: timeout_q       <= cfg_i.wdata;
        necd_pkg::CfgExpAddr: disp_q.exp_addr <= cfg_i.wdata[necd_pkg::ByteW-1:0];
        necd_pkg::CfgVolUp:   disp_q.vol_up   <= cfg_i.wdata[necd_pkg::ByteW-1:0];
        necd_pkg::CfgVolDown: disp_q.vol_down <= cfg_i.wdata[necd_pkg::ByteW-1:0];
        necd_pkg::CfgMute:    disp_q.mute     <= cfg_i.wdata[necd_pkg::ByteW-1:0];
        default: ;
      endcase
    end
  end

  // Input register
  logic                       in_valid_q;
  logic [necd_pkg::TickW-1:0] period_q;
  logic                       proc_go;
  logic                       out_valid_q;

  assign proc_go    = in_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !in_valid_q || proc_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      period_q <= in_i.period_count;
    end
  end

  // Frame state
  logic [necd_pkg::IdxW-1:0]   idx_q, idx_d;
  logic [necd_pkg::FrameW-1:0] shift_q, shift_d;
  logic                        bad_q, bad_d;

  logic timeout_hit, is_data, lt_zero, lt_one, gt_max, bit_bad, bit_val, frame_done;

  // Classify the period: timeout, then zero/one/bad in fixed order
  assign timeout_hit = (period_q >= timeout_q);
  assign is_data     = (idx_q != '0);
  assign lt_zero     = (period_q < min_zero_q);
  assign lt_one      = (period_q < min_one_q);
  assign gt_max      = (period_q > max_one_q);
  assign bit_bad     = lt_zero || (!lt_one && gt_max);
  assign bit_val     = !lt_zero && !lt_one && !gt_max;

  always_comb begin
    shift_d = is_data ? {shift_q[necd_pkg::FrameW-2:0], bit_val} : shift_q;
    bad_d   = bad_q || (is_data && bit_bad);
    idx_d   = idx_q + 1'b1;
  end

  assign frame_done = (idx_d == necd_pkg::FramePeriods);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      shift_q <= '0;
      bad_q   <= 1'b0;
    end else if (proc_go) begin
      if (timeout_hit || frame_done) begin
        idx_q   <= '0;
        shift_q <= '0;
        bad_q   <= 1'b0;
      end else begin
        idx_q   <= idx_d;
        shift_q <= shift_d;
        bad_q   <= bad_d;
      end
    end
  end

  // Frame check on the completed bits
  necd_pkg::result_t check_res, res_d, res_q;

  necd_frame_check u_frame_check (
    .frame_i      (shift_d),
    .timing_bad_i (bad_d),
    .cfg_i        (disp_q),
    .result_o     (check_res)
  );

  always_comb begin
    if (timeout_hit) begin
      res_d = '{status: necd_pkg::StatusTimeout, address: '0, command: '0,
                action: necd_pkg::ActNone};
    end else begin
      res_d = check_res;
    end
  end

  // Result register
  logic emit;
  assign emit = proc_go && (timeout_hit || frame_done);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      res_q <= res_d;
    end
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.status  = res_q.status;
  assign out_o.address = res_q.address;
  assign out_o.command = res_q.command;
  assign out_o.action  = res_q.action;

endmodule

FILE: rtl/necd_checker.sv
// necd_checker: port-level assertions for nec_ir_frame_decoder, bound to the top level.
// Depends on necd_pkg for the status and action codes.

module necd_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input necd_pkg::status_e out_status_i,
  input logic [necd_pkg::ByteW-1:0] out_address_i,
  input logic [necd_pkg::ByteW-1:0] out_command_i,
  input necd_pkg::action_e out_action_i
);

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  // A failed frame carries no decoded bytes
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_status_i != necd_pkg::StatusOk |->
      out_address_i == '0 && out_command_i == '0)
    else $error("failed frame carries data");

  // An action only comes with a good frame
  a_act_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_action_i != necd_pkg::ActNone |->
      out_status_i == necd_pkg::StatusOk)
    else $error("action on a failed frame");

  // A new result rises only after an accepted input item
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_valid_i && in_ready_i, 2))
    else $error("result without an accepted item");

endmodule

bind nec_ir_frame_decoder necd_checker u_necd_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .out_status_i  (out_o.status),
  .out_address_i (out_o.address),
  .out_command_i (out_o.command),
  .out_action_i  (out_o.action)
);

FILE: tb/sv/nec_ir_frame_decoder_test.sv
// nec_ir_frame_decoder_test: self-checking bench for the NEC IR frame decoder.
// Depends on necd_pkg, the channels in necd_if and the nec_ir_frame_decoder RTL.
// Directed edge cases first, then random frames under random source gaps and sink stalls.

module nec_ir_frame_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TickW    = necd_pkg::TickW;
  localparam int unsigned ByteW    = necd_pkg::ByteW;
  localparam int unsigned IdxW     = necd_pkg::IdxW;
  localparam int unsigned FrameW   = necd_pkg::FrameW;
  localparam int unsigned CfgDataW = necd_pkg::CfgDataW;

  localparam int unsigned RandomItems = 700;
  localparam int unsigned PhaseItems  = 175;
  localparam logic [TickW-1:0] TickMax = '1;

  logic clk_i;
  logic rst_ni;

  necd_in_if  period_ch ();
  necd_out_if frame_ch ();
  necd_cfg_if cfg_ch ();

  nec_ir_frame_decoder uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (period_ch),
    .out_o  (frame_ch),
    .cfg_i  (cfg_ch)
  );

  // Decoder copy: registers
  logic [TickW-1:0] zero_floor, min_one, max_one, timeout_lim;
  logic [ByteW-1:0] exp_addr, code_up, code_down, code_mute;

  // Decoder copy: frame in progress
  logic [IdxW-1:0]   frame_pos;
  logic [FrameW-1:0] frame_bits;
  logic              frame_bad;

  necd_pkg::result_t frames_due[$];
  int          error_count  = 0;
  int unsigned periods_sent = 0;
  int unsigned gap_pct      = 0;
  int unsigned stall_pct    = 0;
  int unsigned hold_cycles  = 0;

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Hard stop for a hung handshake
  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Frame decoding, kept in step with every accepted period
  // ---------------------------------------------------------------------------

  function automatic necd_pkg::action_e lookup_action(logic [ByteW-1:0] addr,
                                                      logic [ByteW-1:0] cmd);
    if (addr == '0 && cmd == '0) return necd_pkg::ActNone;
    if (addr != exp_addr) return necd_pkg::ActNone;
    if (cmd == code_up) return necd_pkg::ActVolUp;
    if (cmd == code_down) return necd_pkg::ActVolDown;
    if (cmd == code_mute) return necd_pkg::ActMute;
    return necd_pkg::ActNone;
  endfunction

  function automatic void clear_frame();
    frame_pos  = '0;
    frame_bits = '0;
    frame_bad  = 1'b0;
  endfunction

  function automatic void decode_period(logic [TickW-1:0] p);
    necd_pkg::result_t r;
    logic    bit_val;
    r.status  = necd_pkg::StatusTimeout;
    r.address = '0;
    r.command = '0;
    r.action  = necd_pkg::ActNone;
    if (p >= timeout_lim) begin
      clear_frame();
      frames_due.push_back(r);
      return;
    end
    // leader is taken without a check; data periods are classified in order
    if (frame_pos != '0) begin
      bit_val = 1'b0;
      if (p < zero_floor) frame_bad = 1'b1;
      else if (p < min_one) bit_val = 1'b0;
      else if (p > max_one) frame_bad = 1'b1;
      else bit_val = 1'b1;
      frame_bits = {frame_bits[FrameW-2:0], bit_val};
    end
    frame_pos = frame_pos + 1'b1;
    if (frame_pos < necd_pkg::FramePeriods) return;
    if (frame_bad) r.status = necd_pkg::StatusBadTime;
    else if (frame_bits[31:24] != ~frame_bits[23:16]) r.status = necd_pkg::StatusAddrFail;
    else if (frame_bits[15:8] != ~frame_bits[7:0]) r.status = necd_pkg::StatusCmdFail;
    else begin
      r.status  = necd_pkg::StatusOk;
      r.address = frame_bits[31:24];
      r.command = frame_bits[15:8];
      r.action  = lookup_action(r.address, r.command);
    end
    clear_frame();
    frames_due.push_back(r);
  endfunction

  // ---------------------------------------------------------------------------
  // Channel drivers
  // ---------------------------------------------------------------------------

  task automatic write_reg(necd_pkg::cfg_idx_e idx, logic [CfgDataW-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wdata     <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    case (idx)
      necd_pkg::CfgMinZero: zero_floor  = data;
      necd_pkg::CfgMinOne:  min_one     = data;
      necd_pkg::CfgMaxOne:  max_one     = data;
      necd_pkg::CfgTimeout: timeout_lim = data;
      necd_pkg::CfgExpAddr: exp_addr    = data[ByteW-1:0];
      necd_pkg::CfgVolUp:   code_up     = data[ByteW-1:0];
      necd_pkg::CfgVolDown: code_down   = data[ByteW-1:0];
      necd_pkg::CfgMute:    code_mute   = data[ByteW-1:0];
      default: ;
    endcase
    @(posedge clk_i);
  endtask

  // One period item; an optional gap first, then hold until accepted
  task automatic send_period(logic [TickW-1:0] p);
    if (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
      period_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    period_ch.valid        <= 1'b1;
    period_ch.period_count <= p;
    do @(posedge clk_i); while (!period_ch.ready);
    decode_period(p);
    periods_sent++;
  endtask

  // Stop offering and wait out every pending result plus the pipeline
  task automatic drain();
    period_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (frames_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Period picks under the current thresholds
  // ---------------------------------------------------------------------------

  function automatic logic [TickW-1:0] span(int lo, int hi);
    if (hi < lo) return TickW'(lo);
    return TickW'($urandom_range(hi, lo));
  endfunction

  function automatic logic [TickW-1:0] zero_period();
    return span(int'(zero_floor), int'(min_one) - 1);
  endfunction

  function automatic logic [TickW-1:0] one_period();
    return span(int'(min_one), int'(max_one));
  endfunction

  function automatic logic [TickW-1:0] leader_period();
    return span(0, int'(timeout_lim) - 1);
  endfunction

  function automatic logic [TickW-1:0] timeout_period();
    return span(int'(timeout_lim), int'(TickMax));
  endfunction

  // Too short or too long, but below the timeout where possible
  function automatic logic [TickW-1:0] bad_period();
    if (zero_floor != '0 && (int'(max_one) + 1 >= int'(timeout_lim) || $urandom_range(1)))
      return span(0, int'(zero_floor) - 1);
    return span(int'(max_one) + 1, int'(timeout_lim) - 1);
  endfunction

  function automatic logic [FrameW-1:0] nec_word(logic [ByteW-1:0] a, logic [ByteW-1:0] c);
    return {a, ~a, c, ~c};
  endfunction

  // Leader plus 32 data periods, MSB first; one period may be forced to a bad value.
  // At the edges the periods sit exactly on the thresholds.
  task automatic send_frame(logic [FrameW-1:0] word, int bad_at,
                            logic [TickW-1:0] bad_val, bit at_edges);
    logic [TickW-1:0] p;
    send_period(at_edges ? TickW'(int'(timeout_lim) - 1) : leader_period());
    for (int i = FrameW - 1; i >= 0; i--) begin
      if (i == bad_at) p = bad_val;
      else if (at_edges)
        p = word[i] ? (i[0] ? min_one : max_one)
                    : (i[0] ? zero_floor : TickW'(int'(min_one) - 1));
      else p = word[i] ? one_period() : zero_period();
      send_period(p);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result sink and checker
  // ---------------------------------------------------------------------------

  // Sink ready: random stall bursts, or a long hold-off on request
  initial begin
    int unsigned burst;
    frame_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_cycles > 0) begin
        frame_ch.ready <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
        frame_ch.ready <= 1'b1;
      end else if (stall_pct > 0 && $urandom_range(99) < stall_pct) begin
        burst = $urandom_range(1, 7);
        frame_ch.ready <= 1'b0;
        repeat (burst) @(posedge clk_i);
        frame_ch.ready <= 1'b1;
      end else begin
        frame_ch.ready <= 1'b1;
      end
    end
  end

  initial begin
    necd_pkg::result_t want;
    forever begin
      @(posedge clk_i);
      if (rst_ni && frame_ch.valid && frame_ch.ready) begin
        if (frames_due.size() == 0) begin
          $error("result with none pending: status %0d", frame_ch.status);
          error_count++;
        end else begin
          want = frames_due.pop_front();
          if (frame_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, frame_ch.status);
            error_count++;
          end
          if (frame_ch.address !== want.address) begin
            $error("address: expected %0h, actual %0h", want.address, frame_ch.address);
            error_count++;
          end
          if (frame_ch.command !== want.command) begin
            $error("command: expected %0h, actual %0h", want.command, frame_ch.command);
            error_count++;
          end
          if (frame_ch.action !== want.action) begin
            $error("action: expected %0d, actual %0d", want.action, frame_ch.action);
            error_count++;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset thresholds: periods right on each limit, both-zero frame, bad bits
  task automatic test_bit_edges();
    gap_pct   = 10;
    stall_pct = 5;
    send_frame(nec_word(8'hA5, 8'h3C), -1, '0, 1'b1);
    send_frame(nec_word(8'h00, 8'h00), -1, '0, 1'b0);
    send_frame(nec_word(8'h00, 8'h55), -1, '0, 1'b0);
    send_frame(nec_word(8'h5A, 8'hC3), 31, TickW'(int'(zero_floor) - 1), 1'b1);
    send_frame(nec_word(8'h5A, 8'hC3), 0, TickW'(int'(max_one) + 1), 1'b1);
    drain();
  endtask

  // Timeout on the leader, at the exact limit, mid-frame; all-zero periods
  task automatic test_timeouts();
    send_period(TickMax);
    send_period(timeout_lim);
    send_period(TickW'(int'(timeout_lim) - 1));
    repeat (5) send_period(zero_period());
    send_period(timeout_lim);
    send_frame(nec_word(8'h00, 8'hFF), -1, '0, 1'b0);
    repeat (33) send_period('0);
    drain();
  endtask

  // Bad timing over address check over command check
  task automatic test_status_priority();
    send_frame(32'h1212_34CB, 10, '0, 1'b0);
    send_frame(32'h1212_3434, -1, '0, 1'b0);
    send_frame(32'h12ED_3434, -1, '0, 1'b0);
    drain();
  endtask

  // Address match and command codes, equal codes, byte registers at the extremes
  task automatic test_dispatch();
    write_reg(necd_pkg::CfgExpAddr, 14'h0012);
    write_reg(necd_pkg::CfgVolUp,   14'h0010);
    write_reg(necd_pkg::CfgVolDown, 14'h0010);
    write_reg(necd_pkg::CfgMute,    14'h0030);
    send_frame(nec_word(8'h12, 8'h10), -1, '0, 1'b0);
    send_frame(nec_word(8'h12, 8'h30), -1, '0, 1'b0);
    send_frame(nec_word(8'h13, 8'h10), -1, '0, 1'b0);
    send_frame(nec_word(8'h12, 8'h77), -1, '0, 1'b0);
    drain();
    write_reg(necd_pkg::CfgVolDown, 14'h0020);
    write_reg(necd_pkg::CfgMute,    14'h0020);
    send_frame(nec_word(8'h12, 8'h20), -1, '0, 1'b0);
    drain();
    write_reg(necd_pkg::CfgExpAddr, TickMax);
    write_reg(necd_pkg::CfgVolUp,   TickMax);
    write_reg(necd_pkg::CfgVolDown, TickMax);
    write_reg(necd_pkg::CfgMute,    TickMax);
    send_frame(nec_word(8'hFF, 8'hFF), -1, '0, 1'b0);
    drain();
    write_reg(necd_pkg::CfgExpAddr, '0);
    write_reg(necd_pkg::CfgVolUp,   '0);
    write_reg(necd_pkg::CfgVolDown, '0);
    write_reg(necd_pkg::CfgMute,    '0);
    send_frame(nec_word(8'h00, 8'h00), -1, '0, 1'b0);
    drain();
  endtask

  // Sink holds off while the source keeps offering; then the source waits it out
  task automatic test_backpressure();
    gap_pct     = 0;
    stall_pct   = 0;
    hold_cycles = 200;
    repeat (40) send_period(TickMax);
    drain();
    hold_cycles = 120;
    send_frame(nec_word(8'h44, 8'h21), -1, '0, 1'b0);
    repeat (6) send_period(TickMax);
    drain();
  endtask

  // Inverted thresholds, then a zero timeout under which every period times out
  task automatic test_timeout_zero();
    write_reg(necd_pkg::CfgMinZero, TickMax);
    write_reg(necd_pkg::CfgMinOne,  '0);
    write_reg(necd_pkg::CfgMaxOne,  '0);
    write_reg(necd_pkg::CfgTimeout, TickMax);
    send_frame(nec_word(8'h81, 8'h18), -1, '0, 1'b0);
    drain();
    write_reg(necd_pkg::CfgTimeout, '0);
    send_period('0);
    send_period(TickMax);
    send_period(TickW'($urandom));
    drain();
  endtask

  task automatic random_config(int unsigned style);
    int unsigned      to, mx, mo, mz;
    logic [ByteW-1:0] up, down;
    case (style)
      0: begin
        to = $urandom_range(16383, 64);
        mx = $urandom_range(to - 1, 3);
        mo = $urandom_range(mx, 2);
        mz = $urandom_range(mo - 1, 0);
      end
      1: begin
        mz = 0; mo = 1; mx = 2; to = 3;
      end
      2: begin
        mz = 16380; mo = 16381; mx = 16382; to = 16383;
      end
      default: begin
        mz = $urandom_range(16383);
        mo = $urandom_range(16383);
        mx = $urandom_range(16383);
        to = $urandom_range(16383, 1);
      end
    endcase
    write_reg(necd_pkg::CfgMinZero, TickW'(mz));
    write_reg(necd_pkg::CfgMinOne,  TickW'(mo));
    write_reg(necd_pkg::CfgMaxOne,  TickW'(mx));
    write_reg(necd_pkg::CfgTimeout, TickW'(to));
    // equal command codes now and then, to exercise the match order
    up   = ByteW'($urandom);
    down = $urandom_range(2) == 0 ? up : ByteW'($urandom);
    write_reg(necd_pkg::CfgExpAddr, TickW'($urandom));
    write_reg(necd_pkg::CfgVolUp,   {6'($urandom), up});
    write_reg(necd_pkg::CfgVolDown, {6'($urandom), down});
    write_reg(necd_pkg::CfgMute,    $urandom_range(2) == 0 ? {6'd0, down} : TickW'($urandom));
  endtask

  // Mostly well-formed frames with random content; the rest broken frames and noise
  task automatic test_random_frames();
    int unsigned       start, phase, phase_end, kind, n;
    bit                last;
    logic [ByteW-1:0]  addr, cmd;
    logic [FrameW-1:0] word;
    start = periods_sent;
    phase = 0;
    while (periods_sent < start + RandomItems) begin
      last = (start + RandomItems - periods_sent) <= PhaseItems;
      drain();
      random_config(phase % 4);
      phase++;
      phase_end = periods_sent + PhaseItems;
      while (periods_sent < phase_end) begin
        gap_pct   = last ? 0 : 10 * $urandom_range(0, 3);
        stall_pct = last ? 0 : 5 * $urandom_range(0, 3);
        addr = $urandom_range(3) != 0 ? exp_addr : ByteW'($urandom);
        case ($urandom_range(4))
          0:       cmd = code_up;
          1:       cmd = code_down;
          2:       cmd = code_mute;
          3:       cmd = '0;
          default: cmd = ByteW'($urandom);
        endcase
        word = nec_word(addr, cmd);
        kind = $urandom_range(99);
        // realign on a frame start before anything that should decode
        if (kind < 88 && frame_pos != '0) send_period(timeout_period());
        if (kind < 55) send_frame(word, -1, '0, 1'b0);
        else if (kind < 65) send_frame(word ^ (32'd1 << $urandom_range(31)), -1, '0, 1'b0);
        else if (kind < 75) send_frame(word, $urandom_range(31), bad_period(), 1'b0);
        else if (kind < 80) send_frame(word, -1, '0, 1'b1);
        else if (kind < 88) begin
          n = $urandom_range(31);
          send_period(leader_period());
          repeat (n) send_period($urandom_range(1) ? one_period() : zero_period());
          send_period(timeout_period());
        end else begin
          repeat ($urandom_range(1, 12)) send_period(TickW'($urandom));
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    rst_ni                 <= 1'b0;
    period_ch.valid        <= 1'b0;
    period_ch.period_count <= '0;
    cfg_ch.valid           <= 1'b0;
    cfg_ch.reg_index       <= '0;
    cfg_ch.wdata           <= '0;
    zero_floor  = necd_pkg::MinZeroRst;
    min_one     = necd_pkg::MinOneRst;
    max_one     = necd_pkg::MaxOneRst;
    timeout_lim = necd_pkg::TimeoutRst;
    exp_addr    = necd_pkg::CodeRst;
    code_up     = necd_pkg::CodeRst;
    code_down   = necd_pkg::CodeRst;
    code_mute   = necd_pkg::CodeRst;
    clear_frame();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_bit_edges();
    test_timeouts();
    test_status_priority();
    test_dispatch();
    test_backpressure();
    test_timeout_zero();
    test_random_frames();

    drain();
    repeat (6) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
